FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the watchdog table checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on clk, muted while arst_n is low
`define SSWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same-cycle implication
`define SSWT_ASSERT_IMPL(lbl, ante, cons, msg) \
	`SSWT_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define SSWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	`SSWT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/sswt_pkg.sv
// ----------------------------------------------------------------------------
// sswt_pkg
// Types, codes and constants shared by the watchdog table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sswt_pkg;

	localparam int unsigned TIME_W     = 48;
	localparam int unsigned OWNER_W    = 32;
	localparam int unsigned TAG_W      = 16;
	localparam int unsigned SLOT_W     = 6;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned FIRST_W    = 16;
	localparam int unsigned IVL_W      = 17;
	localparam int unsigned HANG_W     = 20;
	localparam int unsigned SLOW_W     = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [FIRST_W-1:0] FIRST_RST = 16'd2000;
	localparam logic [IVL_W-1:0]   MAXI_RST  = 17'd60000;
	localparam logic [HANG_W-1:0]  HANG_RST  = 20'd20000;
	localparam logic [SLOW_W-1:0]  SLOW_RST  = 16'd250;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_SCAN  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST = 2'd0,
		REG_MAXI  = 2'd1,
		REG_HANG  = 2'd2,
		REG_SLOW  = 2'd3
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_GRANTED     = 3'd0,
		KIND_REFUSED     = 3'd1,
		KIND_CLOSED      = 3'd2,
		KIND_CLOSED_SLOW = 3'd3,
		KIND_RUNNING     = 3'd4,
		KIND_NONE        = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_CLOSE_RD,
		ST_CLOSE,
		ST_SCAN,
		ST_SCAN_END
	} state_t;

	typedef struct packed {
		logic [FIRST_W-1:0] first;
		logic [IVL_W-1:0]   max_ivl;
		logic [HANG_W-1:0]  hang;
		logic [SLOW_W-1:0]  slow;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [TIME_W-1:0]  now;
		logic [SLOT_W-1:0]  slot;
		logic [OWNER_W-1:0] owner;
		logic [TAG_W-1:0]   tag;
	} req_t;

	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot_index;
		logic [OWNER_W-1:0] owner;
		logic [TAG_W-1:0]   label_tag;
		logic [TIME_W-1:0]  age;
		logic               hang_dump;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} push_t;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [TAG_W-1:0]   tag;
		logic [TIME_W-1:0]  start;
		logic [TIME_W-1:0]  due;
		logic [IVL_W-1:0]   interval;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/sswt_ifs.sv
// ----------------------------------------------------------------------------
// sswt_ifs
// Request and result channels of the watchdog table.
// ----------------------------------------------------------------------------
`default_nettype none

interface sswt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [47:0] now_ms;
	logic [5:0]  slot;
	logic [31:0] owner_id;
	logic [15:0] tag;

	modport source (output valid, command, now_ms, slot, owner_id, tag, input ready);
	modport sink   (input valid, command, now_ms, slot, owner_id, tag, output ready);
endinterface

interface sswt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [5:0]  slot_index;
	logic [31:0] owner;
	logic [15:0] label_tag;
	logic [47:0] age_ms;
	logic        hang_dump;
	logic        last;

	modport source (output valid, kind, slot_index, owner, label_tag, age_ms, hang_dump, last,
		input ready);
	modport sink   (input valid, kind, slot_index, owner, label_tag, age_ms, hang_dump, last,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/sswt_ram.sv
// ----------------------------------------------------------------------------
// sswt_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sswt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sswt_ctrl.sv
// ----------------------------------------------------------------------------
// sswt_ctrl
// Command sequencer: slot allocation, close lookup and pipelined scan walk
// over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sswt_ctrl #(
	parameter int unsigned SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sswt_pkg::req_t   req_data,
	input  sswt_pkg::cfg_t   cfg,
	input  logic             can_push,
	output sswt_pkg::push_t  push
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [sswt_pkg::SLOT_W:0] SLOT_LIM = (sswt_pkg::SLOT_W + 1)'(SLOTS);

	sswt_pkg::state_t state_q, state_d;
	sswt_pkg::req_t   req_q, req_d;
	logic [SLOTS-1:0] busy_q, busy_d;
	logic             hang_latched_q, hang_latched_d;
	logic [CW-1:0]    rd_idx_q, rd_idx_d;
	logic             valid_s1, valid_s1_d;
	logic [IW-1:0]    idx_s1, idx_s1_d;
	logic             pend_valid_q, pend_valid_d;
	sswt_pkg::rsp_t   pend_q, pend_d;
	logic             any_hang_q, any_hang_d;

	logic             we, re;
	logic [IW-1:0]    waddr, raddr;
	sswt_pkg::entry_t wentry, rentry;

	logic                        free_found;
	logic [IW-1:0]               free_idx;
	logic                        slot_ok;
	logic [sswt_pkg::TIME_W-1:0] age;
	logic                        due_hit, is_hang, is_slow, stall, rd_more;
	logic [sswt_pkg::IVL_W:0]    dbl;
	logic [sswt_pkg::IVL_W-1:0]  new_ivl;
	logic [sswt_pkg::TIME_W-1:0] new_due;

	sswt_ram #(
		.WIDTH (sswt_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.re    (re),
		.raddr (raddr),
		.rdata (rentry)
	);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	assign slot_ok = ({1'b0, req_data.slot} < SLOT_LIM) && busy_q[req_data.slot[IW-1:0]];

	assign age     = req_q.now - rentry.start;
	assign due_hit = valid_s1 && (req_q.now >= rentry.due);
	assign is_hang = age >= sswt_pkg::TIME_W'(cfg.hang);
	assign is_slow = age >= sswt_pkg::TIME_W'(cfg.slow);
	assign dbl     = {rentry.interval, 1'b0};
	assign new_ivl = (dbl < {1'b0, cfg.max_ivl}) ? dbl[sswt_pkg::IVL_W-1:0] : cfg.max_ivl;
	assign new_due = req_q.now + sswt_pkg::TIME_W'(new_ivl);
	assign stall   = due_hit && pend_valid_q && !can_push;
	assign rd_more = rd_idx_q < CW'(SLOTS);

	assign req_ready = (state_q == sswt_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= sswt_pkg::ST_IDLE;
			busy_q         <= '0;
			hang_latched_q <= 1'b0;
			rd_idx_q       <= '0;
			valid_s1       <= 1'b0;
			pend_valid_q   <= 1'b0;
			any_hang_q     <= 1'b0;
		end else begin
			state_q        <= state_d;
			busy_q         <= busy_d;
			hang_latched_q <= hang_latched_d;
			rd_idx_q       <= rd_idx_d;
			valid_s1       <= valid_s1_d;
			pend_valid_q   <= pend_valid_d;
			any_hang_q     <= any_hang_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		idx_s1 <= idx_s1_d;
		pend_q <= pend_d;
	end

	always_comb begin
		state_d        = state_q;
		req_d          = req_q;
		busy_d         = busy_q;
		hang_latched_d = hang_latched_q;
		rd_idx_d       = rd_idx_q;
		valid_s1_d     = valid_s1;
		idx_s1_d       = idx_s1;
		pend_valid_d   = pend_valid_q;
		pend_d         = pend_q;
		any_hang_d     = any_hang_q;
		push           = '0;
		we             = 1'b0;
		waddr          = idx_s1;
		wentry         = rentry;
		re             = 1'b0;
		raddr          = rd_idx_q[IW-1:0];

		case (state_q)
			sswt_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_d = req_data;
					case (req_data.command)
						sswt_pkg::CMD_OPEN: begin
							state_d = sswt_pkg::ST_OPEN;
						end
						sswt_pkg::CMD_CLOSE: begin
							if (slot_ok) begin
								state_d = sswt_pkg::ST_CLOSE_RD;
							end
						end
						sswt_pkg::CMD_SCAN: begin
							state_d      = sswt_pkg::ST_SCAN;
							rd_idx_d     = '0;
							valid_s1_d   = 1'b0;
							pend_valid_d = 1'b0;
							any_hang_d   = 1'b0;
						end
						default: begin
							state_d = sswt_pkg::ST_IDLE;
						end
					endcase
				end
			end

			sswt_pkg::ST_OPEN: begin
				if (can_push) begin
					push.valid          = 1'b1;
					push.data.owner     = req_q.owner;
					push.data.label_tag = req_q.tag;
					push.data.last      = 1'b1;
					if (free_found) begin
						push.data.kind       = sswt_pkg::KIND_GRANTED;
						push.data.slot_index = sswt_pkg::SLOT_W'(free_idx);
						we                   = 1'b1;
						waddr                = free_idx;
						wentry.owner         = req_q.owner;
						wentry.tag           = req_q.tag;
						wentry.start         = req_q.now;
						wentry.interval      = sswt_pkg::IVL_W'(cfg.first);
						wentry.due           = req_q.now + sswt_pkg::TIME_W'(cfg.first);
						busy_d[free_idx]     = 1'b1;
					end else begin
						push.data.kind = sswt_pkg::KIND_REFUSED;
					end
					state_d = sswt_pkg::ST_IDLE;
				end
			end

			sswt_pkg::ST_CLOSE_RD: begin
				re      = 1'b1;
				raddr   = req_q.slot[IW-1:0];
				state_d = sswt_pkg::ST_CLOSE;
			end

			sswt_pkg::ST_CLOSE: begin
				if (can_push) begin
					push.valid           = 1'b1;
					push.data.kind       = is_slow ? sswt_pkg::KIND_CLOSED_SLOW
						: sswt_pkg::KIND_CLOSED;
					push.data.slot_index = req_q.slot;
					push.data.owner      = rentry.owner;
					push.data.label_tag  = rentry.tag;
					push.data.age        = age;
					push.data.last       = 1'b1;
					busy_d[req_q.slot[IW-1:0]] = 1'b0;
					state_d = sswt_pkg::ST_IDLE;
				end
			end

			sswt_pkg::ST_SCAN: begin
				if (!stall) begin
					if (rd_more) begin
						re         = 1'b1;
						raddr      = rd_idx_q[IW-1:0];
						valid_s1_d = busy_q[rd_idx_q[IW-1:0]];
						idx_s1_d   = rd_idx_q[IW-1:0];
						rd_idx_d   = rd_idx_q + 1'b1;
					end else begin
						valid_s1_d = 1'b0;
						if (!valid_s1) begin
							state_d = sswt_pkg::ST_SCAN_END;
						end
					end
					if (due_hit) begin
						we              = 1'b1;
						waddr           = idx_s1;
						wentry.interval = new_ivl;
						wentry.due      = new_due;
						if (pend_valid_q) begin
							push.valid = 1'b1;
							push.data  = pend_q;
						end
						pend_valid_d      = 1'b1;
						pend_d            = '0;
						pend_d.kind       = sswt_pkg::KIND_RUNNING;
						pend_d.slot_index = sswt_pkg::SLOT_W'(idx_s1);
						pend_d.owner      = rentry.owner;
						pend_d.label_tag  = rentry.tag;
						pend_d.age        = age;
						any_hang_d        = any_hang_q | is_hang;
					end
				end
			end

			sswt_pkg::ST_SCAN_END: begin
				if (can_push) begin
					push.valid = 1'b1;
					if (pend_valid_q) begin
						push.data           = pend_q;
						push.data.hang_dump = any_hang_q && !hang_latched_q;
						hang_latched_d      = hang_latched_q | any_hang_q;
					end else begin
						push.data.kind = sswt_pkg::KIND_NONE;
					end
					push.data.last = 1'b1;
					pend_valid_d   = 1'b0;
					state_d        = sswt_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = sswt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/stuck_scope_watchdog_table.sv
// ----------------------------------------------------------------------------
// stuck_scope_watchdog_table
// Multi-slot watchdog for open operations: open, close and periodic scan
// with doubling report intervals and a one-shot hang flag.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     command, now_ms, slot, owner_id, tag
//   rsp      out  valid/ready     kind, slot_index, owner, label_tag, age_ms,
//                                 hang_dump, last
//   cfg      in   cfg_we          cfg_index, cfg_wdata
//
// A scan reads the slots in index order, one slot read per cycle unless a
// stalled rsp holds the walk.
// Each request is worked alone; req.ready is high only between requests.
// A stalled rsp holds the sequencer where it must push the next result.
// Reset clears the busy flags, the hang latch and the registers to defaults;
// the slot memory needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stuck_scope_watchdog_table #(
	parameter int unsigned SLOTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sswt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sswt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	sswt_req_if.sink                           req,
	sswt_rsp_if.source                         rsp
);

	sswt_pkg::cfg_t  cfg_q;
	sswt_pkg::req_t  req_data;
	sswt_pkg::push_t push;
	sswt_pkg::rsp_t  out_q;
	logic            out_valid_q;
	logic            can_push;
	logic            ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first   <= sswt_pkg::FIRST_RST;
			cfg_q.max_ivl <= sswt_pkg::MAXI_RST;
			cfg_q.hang    <= sswt_pkg::HANG_RST;
			cfg_q.slow    <= sswt_pkg::SLOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sswt_pkg::REG_FIRST: cfg_q.first   <= cfg_wdata[sswt_pkg::FIRST_W-1:0];
				sswt_pkg::REG_MAXI:  cfg_q.max_ivl <= cfg_wdata[sswt_pkg::IVL_W-1:0];
				sswt_pkg::REG_HANG:  cfg_q.hang    <= cfg_wdata[sswt_pkg::HANG_W-1:0];
				sswt_pkg::REG_SLOW:  cfg_q.slow    <= cfg_wdata[sswt_pkg::SLOW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req_data.command = req.command;
	assign req_data.now     = req.now_ms;
	assign req_data.slot    = req.slot;
	assign req_data.owner   = req.owner_id;
	assign req_data.tag     = req.tag;
	assign req.ready        = ready;

	assign can_push = !out_valid_q || rsp.ready;

	sswt_ctrl #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.req_data  (req_data),
		.cfg       (cfg_q),
		.can_push  (can_push),
		.push      (push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push.data;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_q.kind;
	assign rsp.slot_index = out_q.slot_index;
	assign rsp.owner      = out_q.owner;
	assign rsp.label_tag  = out_q.label_tag;
	assign rsp.age_ms     = out_q.age;
	assign rsp.hang_dump  = out_q.hang_dump;
	assign rsp.last       = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/sswt_checker.sv
// ----------------------------------------------------------------------------
// sswt_checker
// Port-level checks of the watchdog table result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sswt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_kind,
	input logic [5:0]  rsp_slot_index,
	input logic [47:0] rsp_age_ms,
	input logic        rsp_hang_dump,
	input logic        rsp_last
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (rsp_valid && rsp_ready && rsp_hang_dump) begin
			seen_q <= 1'b1;
		end
	end

	`SSWT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_age_ms) && $stable(rsp_last), "result changed while stalled")
	`SSWT_ASSERT_IMPL(a_hang_once, rsp_valid && rsp_hang_dump, !seen_q, "hang flag raised twice")
	`SSWT_ASSERT_IMPL(a_hang_place, rsp_valid && rsp_hang_dump, rsp_last && (rsp_kind == sswt_pkg::KIND_RUNNING), "hang flag off the last report")
	`SSWT_ASSERT_IMPL(a_single, rsp_valid && ((rsp_kind == sswt_pkg::KIND_GRANTED) || (rsp_kind == sswt_pkg::KIND_REFUSED) || (rsp_kind == sswt_pkg::KIND_CLOSED) || (rsp_kind == sswt_pkg::KIND_CLOSED_SLOW)), rsp_last && !rsp_hang_dump, "open or close result not single")
	`SSWT_ASSERT_IMPL(a_none_due, rsp_valid && (rsp_kind == sswt_pkg::KIND_NONE), rsp_last && (rsp_age_ms == '0) && (rsp_slot_index == '0), "nothing-due result not clean")

endmodule

bind stuck_scope_watchdog_table sswt_checker u_sswt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_slot_index (rsp.slot_index),
	.rsp_age_ms     (rsp.age_ms),
	.rsp_hang_dump  (rsp.hang_dump),
	.rsp_last       (rsp.last)
);

`default_nettype wire

FILE: dv/tb_stuck_scope_watchdog_table.sv
// ----------------------------------------------------------------------------
// tb_stuck_scope_watchdog_table
// Self-checking bench for the watchdog table. A queue of commands feeds a
// bursty request driver; every accepted request is run through a slot-table
// model kept in the bench, and the reports it yields are matched field by
// field against the result channel, which stalls on its own pattern. Phases
// cover reset, low and high register extremes, wrap of the millisecond clock,
// a full table with refusals and random register values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stuck_scope_watchdog_table;
	timeunit 1ns;
	timeprecision 1ps;

	import sswt_pkg::*;

	localparam int          CLK_PERIOD  = 10;
	localparam int          TAIL_CYCLES = 80;
	localparam int          HOLD_CYCLES = 400;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          MAX_PRINTS  = 100;
	localparam logic [1:0]  CMD_UNUSED  = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sswt_req_if req_if ();
	sswt_rsp_if rsp_if ();

	stuck_scope_watchdog_table #(.SLOTS(64)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// slot table model
	bit                 tbl_busy  [64];
	logic [OWNER_W-1:0] tbl_owner [64];
	logic [TAG_W-1:0]   tbl_tag   [64];
	logic [TIME_W-1:0]  tbl_start [64];
	logic [TIME_W-1:0]  tbl_due   [64];
	logic [IVL_W-1:0]   tbl_ivl   [64];
	bit                 hang_fired;
	logic [FIRST_W-1:0] cfg_first = FIRST_RST;
	logic [IVL_W-1:0]   cfg_maxi  = MAXI_RST;
	logic [HANG_W-1:0]  cfg_hang  = HANG_RST;
	logic [SLOW_W-1:0]  cfg_slow  = SLOW_RST;

	rsp_t pending_reports [$];
	req_t command_backlog [$];
	req_t in_flight;

	bit                gen_busy [64];
	logic [TIME_W-1:0] clock_ms;
	int                n_sent;
	int                n_taken;
	int                n_errors;
	int                cycle_count;
	int                burst_left;
	int                gap_left;
	int                stall_mode;
	int                mode_left;
	int                hold_left;
	bit                hold_armed;
	bit                hold_done;

	function automatic void run_watch_table(input req_t r);
		rsp_t              found [$];
		rsp_t              one;
		logic [TIME_W-1:0] age;
		logic [IVL_W:0]    dbl;
		bit                any_hang;
		int                hit;
		any_hang = 1'b0;
		hit = -1;
		one = '0;
		case (r.command)
		CMD_OPEN: begin
			for (int i = 0; i < 64; i++)
				if (!tbl_busy[i] && hit < 0)
					hit = i;
			one.owner = r.owner;
			one.label_tag = r.tag;
			one.last = 1'b1;
			if (hit >= 0) begin
				tbl_busy[hit] = 1'b1;
				tbl_owner[hit] = r.owner;
				tbl_tag[hit] = r.tag;
				tbl_start[hit] = r.now;
				tbl_ivl[hit] = IVL_W'(cfg_first);
				tbl_due[hit] = r.now + TIME_W'(cfg_first);
				one.kind = KIND_GRANTED;
				one.slot_index = SLOT_W'(hit);
			end else begin
				one.kind = KIND_REFUSED;
			end
			pending_reports.push_back(one);
		end
		CMD_CLOSE: begin
			if (tbl_busy[r.slot]) begin
				tbl_busy[r.slot] = 1'b0;
				age = r.now - tbl_start[r.slot];
				one.kind = (age >= TIME_W'(cfg_slow)) ? KIND_CLOSED_SLOW : KIND_CLOSED;
				one.slot_index = r.slot;
				one.owner = tbl_owner[r.slot];
				one.label_tag = tbl_tag[r.slot];
				one.age = age;
				one.last = 1'b1;
				pending_reports.push_back(one);
			end
		end
		CMD_SCAN: begin
			for (int i = 0; i < 64; i++) begin
				if (tbl_busy[i] && r.now >= tbl_due[i]) begin
					age = r.now - tbl_start[i];
					if (age >= TIME_W'(cfg_hang))
						any_hang = 1'b1;
					one = '0;
					one.kind = KIND_RUNNING;
					one.slot_index = SLOT_W'(i);
					one.owner = tbl_owner[i];
					one.label_tag = tbl_tag[i];
					one.age = age;
					found.push_back(one);
					dbl = {tbl_ivl[i], 1'b0};
					tbl_ivl[i] = (dbl < (IVL_W + 1)'(cfg_maxi)) ? dbl[IVL_W-1:0] : cfg_maxi;
					tbl_due[i] = r.now + TIME_W'(tbl_ivl[i]);
				end
			end
			if (found.size() == 0) begin
				one = '0;
				one.kind = KIND_NONE;
				one.last = 1'b1;
				found.push_back(one);
			end else begin
				one = found.pop_back();
				one.last = 1'b1;
				if (any_hang && !hang_fired) begin
					hang_fired = 1'b1;
					one.hang_dump = 1'b1;
				end
				found.push_back(one);
			end
			foreach (found[i])
				pending_reports.push_back(found[i]);
		end
		default: begin
		end
		endcase
	endfunction

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [47:0] got,
		input logic [47:0] want);
		if (got !== want)
			report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic check_report();
		rsp_t want;
		if (pending_reports.size() == 0) begin
			report($sformatf("unexpected result kind %0d slot %0d", rsp_if.kind,
				rsp_if.slot_index));
		end else begin
			want = pending_reports.pop_front();
			check_field("kind", 48'(rsp_if.kind), 48'(want.kind));
			check_field("slot_index", 48'(rsp_if.slot_index), 48'(want.slot_index));
			check_field("owner", 48'(rsp_if.owner), 48'(want.owner));
			check_field("label_tag", 48'(rsp_if.label_tag), 48'(want.label_tag));
			check_field("age_ms", rsp_if.age_ms, want.age);
			check_field("hang_dump", 48'(rsp_if.hang_dump), 48'(want.hang_dump));
			check_field("last", 48'(rsp_if.last), 48'(want.last));
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				run_watch_table(in_flight);
				n_taken++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (command_backlog.size() != 0) begin
					in_flight = command_backlog.pop_front();
					req_if.valid <= 1'b1;
					req_if.command <= in_flight.command;
					req_if.now_ms <= in_flight.now;
					req_if.slot <= in_flight.slot;
					req_if.owner_id <= in_flight.owner;
					req_if.tag <= in_flight.tag;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
							: $urandom_range(1, 8);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			mode_left = 0;
			hold_left = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready)
				check_report();
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				case (stall_mode)
				0: rsp_if.ready <= 1'b1;
				1: rsp_if.ready <= 1'($urandom_range(0, 1));
				2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
				default: rsp_if.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_stuck_scope_watchdog_table: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_FIRST: cfg_first = val[FIRST_W-1:0];
		REG_MAXI:  cfg_maxi = val[IVL_W-1:0];
		REG_HANG:  cfg_hang = val[HANG_W-1:0];
		default:   cfg_slow = val[SLOW_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] first, input logic [CFG_DATA_W-1:0] maxi,
		input logic [CFG_DATA_W-1:0] hang, input logic [CFG_DATA_W-1:0] slow);
		write_reg(REG_FIRST, first);
		write_reg(REG_MAXI, maxi);
		write_reg(REG_HANG, hang);
		write_reg(REG_SLOW, slow);
	endtask

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (n_taken != n_sent || pending_reports.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic queue_command(input logic [1:0] cmd, input logic [SLOT_W-1:0] slot,
		input logic [OWNER_W-1:0] owner, input logic [TAG_W-1:0] tag);
		req_t item;
		bit   placed;
		placed = 1'b0;
		item.command = cmd;
		item.now = clock_ms;
		item.slot = slot;
		item.owner = owner;
		item.tag = tag;
		command_backlog.push_back(item);
		n_sent++;
		if (cmd == CMD_OPEN) begin
			for (int i = 0; i < 64; i++)
				if (!gen_busy[i] && !placed) begin
					gen_busy[i] = 1'b1;
					placed = 1'b1;
				end
		end else if (cmd == CMD_CLOSE) begin
			gen_busy[slot] = 1'b0;
		end
	endtask

	task automatic queue_at(input logic [TIME_W-1:0] t, input logic [1:0] cmd,
		input logic [SLOT_W-1:0] slot);
		clock_ms = t;
		queue_command(cmd, slot, $urandom(), TAG_W'($urandom()));
	endtask

	task automatic gen_traffic(input int count, input int step_max, input int open_w,
		input int close_w, input bit pause_midway);
		int made;
		int pick;
		int s;
		bit paused;
		int busy_list [$];
		made = 0;
		paused = 1'b0;
		while (made < count) begin
			if (pause_midway && !paused && made >= count / 2) begin
				paused = 1'b1;
				wait_quiet();
			end
			clock_ms += TIME_W'($urandom_range(0, step_max));
			pick = $urandom_range(0, 99);
			s = $urandom_range(0, 63);
			if (pick < 6) begin
				if ($urandom_range(0, 1) == 0) begin
					queue_command(CMD_UNUSED, SLOT_W'(s), $urandom(), TAG_W'($urandom()));
				end else begin
					if (gen_busy[s])
						made++;
					queue_command(CMD_CLOSE, SLOT_W'(s), $urandom(), TAG_W'($urandom()));
				end
			end else if (pick < 6 + open_w) begin
				queue_command(CMD_OPEN, SLOT_W'(s), $urandom(), TAG_W'($urandom()));
				made++;
			end else if (pick < 6 + open_w + close_w) begin
				busy_list.delete();
				for (int i = 0; i < 64; i++)
					if (gen_busy[i])
						busy_list.push_back(i);
				if (busy_list.size() != 0)
					s = busy_list[$urandom_range(0, busy_list.size() - 1)];
				queue_command(busy_list.size() != 0 ? CMD_CLOSE : CMD_SCAN, SLOT_W'(s),
					$urandom(), TAG_W'($urandom()));
				made++;
			end else begin
				queue_command(CMD_SCAN, SLOT_W'(s), $urandom(), TAG_W'($urandom()));
				made++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FIRST;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.command = CMD_OPEN;
		req_if.now_ms = '0;
		req_if.slot = '0;
		req_if.owner_id = '0;
		req_if.tag = '0;
		rsp_if.ready = 1'b0;
		clock_ms = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small intervals so doubling, cap and hang show up quickly
		write_all(20'd10, 20'd40, 20'd100, 20'd5);
		clock_ms = 48'd0;
		queue_command(CMD_OPEN, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
		clock_ms = 48'd1;
		queue_command(CMD_OPEN, 6'd0, 32'h0, 16'h0);
		queue_at(48'd2, CMD_SCAN, 6'd0);
		queue_at(48'd3, CMD_CLOSE, 6'd1);
		queue_at(48'd4, CMD_CLOSE, 6'd1);
		queue_at(48'd5, CMD_UNUSED, 6'd5);
		queue_at(48'd6, CMD_OPEN, 6'd2);
		queue_at(48'd10, CMD_SCAN, 6'd0);
		queue_at(48'd16, CMD_SCAN, 6'd0);
		queue_at(48'd17, CMD_CLOSE, 6'd63);
		queue_at(48'd40, CMD_SCAN, 6'd0);
		queue_at(48'd120, CMD_SCAN, 6'd0);
		queue_at(48'd200, CMD_SCAN, 6'd0);
		queue_at(48'd201, CMD_CLOSE, 6'd0);
		queue_at(48'd202, CMD_CLOSE, 6'd1);
		queue_at(48'd203, CMD_OPEN, 6'd0);
		queue_at(48'd203, CMD_CLOSE, 6'd0);
		queue_at(48'd210, CMD_OPEN, 6'd0);
		queue_at(48'd215, CMD_CLOSE, 6'd0);
		queue_at(48'd216, CMD_OPEN, 6'd0);
		queue_at(48'd216, CMD_OPEN, 6'd0);
		queue_at(48'd300, CMD_SCAN, 6'd0);
		wait_quiet();

		write_all(20'(FIRST_RST), 20'(MAXI_RST), 20'(HANG_RST), 20'(SLOW_RST));
		gen_traffic(80, 1500, 35, 30, 1'b1);
		wait_quiet();

		write_all(20'd1, 20'd1, 20'd1, 20'd0);
		gen_traffic(80, 3, 35, 30, 1'b0);
		wait_quiet();

		// run across the wrap of the millisecond clock
		write_all(20'hFFFF, 20'h1FFFF, 20'hFFFFF, 20'hFFFF);
		clock_ms = 48'hFFFF_FFFF_FFFF - 48'd300000;
		gen_traffic(70, 40000, 40, 25, 1'b0);
		wait_quiet();

		// fill the table while the result side holds off
		write_all(20'd3, 20'd50, 20'd500, 20'd20);
		hold_armed = 1'b1;
		gen_traffic(120, 4, 70, 4, 1'b0);
		wait_quiet();

		write_all(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
			CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
		gen_traffic(80, 5000, 30, 35, 1'b0);
		wait_quiet();

		if (n_errors == 0)
			$display("tb_stuck_scope_watchdog_table: PASS");
		else
			$display("tb_stuck_scope_watchdog_table: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
